// ===== rtl/ldt_pkg.sv =====
// ----------------------------------------------------------------------------
// ldt_pkg
// Shared types and constants of the limit input debounce and trip unit.
// ----------------------------------------------------------------------------
package ldt_pkg;

  localparam int INPUT_COUNT_DEF = 32;
  localparam int MAX_AXES_DEF    = 9;
  localparam int COUNT_BITS_DEF  = 22;

  localparam int IDX_W         = 5;
  localparam int MAP_W         = 45;
  localparam int STOP_MAP_W    = 10;
  localparam int LIMIT_W       = 20;
  localparam int AXES_W        = 4;
  localparam int WORD_W        = 32;
  localparam int DT_W          = 16;
  localparam int CAUSE_W       = 2;
  localparam int BITS_PER_AXIS = 3;
  localparam int ESTOP_POS     = 31;
  localparam int PROBE_POS     = 30;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MAP_W;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_MAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MAP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_MAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_PROBE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXES       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd10000;
  localparam logic [AXES_W-1:0]  AXES_RESET  = 4'd3;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_ESTOP = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_LIMIT = 2'd2;

  typedef struct packed {
    logic [MAP_W-1:0]      min_map;
    logic [MAP_W-1:0]      max_map;
    logic [MAP_W-1:0]      home_sw_map;
    logic [STOP_MAP_W-1:0] stop_probe_map;
    logic [LIMIT_W-1:0]    limit_us;
    logic [AXES_W-1:0]     axis_count;
    logic [WORD_W-1:0]     invert_mask;
    logic [WORD_W-1:0]     enable_mask;
  } ldt_cfg_t;

endpackage

// ===== rtl/ldt_if.sv =====
// ----------------------------------------------------------------------------
// ldt channel interfaces
// Tick input, result output and register write channels.
// ----------------------------------------------------------------------------
interface ldt_in_if;
  import ldt_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] raw_levels;
  logic [DT_W-1:0]   elapsed_us;
  logic              machine_running;
  modport source (output valid, raw_levels, elapsed_us, machine_running, input ready);
  modport sink   (input valid, raw_levels, elapsed_us, machine_running, output ready);
endinterface

interface ldt_out_if;
  import ldt_pkg::*;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  status_word;
  logic [WORD_W-1:0]  rising_bits;
  logic               stop_request;
  logic [CAUSE_W-1:0] stop_cause;
  modport source (output valid, status_word, rising_bits, stop_request, stop_cause,
                  input ready);
  modport sink   (input valid, status_word, rising_bits, stop_request, stop_cause,
                  output ready);
endinterface

interface ldt_cfg_if;
  import ldt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/limit_input_debounce_and_trip_unit.sv =====
// ----------------------------------------------------------------------------
// limit_input_debounce_and_trip_unit
// Integrating debounce of critical inputs with status mapping, edge detect
// and emergency stop request.
//
//   channel  | dir | handshake     | payload
//   in_ch    | in  | valid / ready | raw_levels, elapsed_us, machine_running
//   out_ch   | out | valid / ready | status_word, rising_bits, stop_request,
//            |     |               | stop_cause
//   cfg_ch   | in  | valid / ready | index, data (ready always high)
//
// A tick is registered at the input, then all counters update in parallel
// and the result is registered at the output; one tick per cycle while the
// output is not stalled. Synchronous active-low reset clears counters,
// levels and status and loads register defaults. A stalled output holds the
// pipeline; the input register takes a tick during a stall only if empty.
// ----------------------------------------------------------------------------
module limit_input_debounce_and_trip_unit #(
  parameter int INPUT_COUNT = ldt_pkg::INPUT_COUNT_DEF,
  parameter int MAX_AXES    = ldt_pkg::MAX_AXES_DEF,
  parameter int COUNT_BITS  = ldt_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ldt_in_if.sink           in_ch,
  ldt_out_if.source        out_ch,
  ldt_cfg_if.sink          cfg_ch
);
  import ldt_pkg::*;

  ldt_cfg_t cfg;

  logic              s1_valid_r;
  logic [WORD_W-1:0] s1_raw_r;
  logic [DT_W-1:0]   s1_dt_r;
  logic              s1_run_r;
  logic              advance;

  logic [WORD_W-1:0]      closed_word;
  logic [INPUT_COUNT-1:0] level_vec;

  logic [WORD_W-1:0]  status_nxt;
  logic [WORD_W-1:0]  rising;
  logic               stop_request;
  logic [CAUSE_W-1:0] stop_cause;

  logic               out_valid_r;
  logic [WORD_W-1:0]  out_status_r;
  logic [WORD_W-1:0]  out_rising_r;
  logic               out_stop_r;
  logic [CAUSE_W-1:0] out_cause_r;

  assign cfg_ch.ready = 1'b1;

  ldt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_raw_r <= in_ch.raw_levels;
      s1_dt_r  <= in_ch.elapsed_us;
      s1_run_r <= in_ch.machine_running;
    end
  end

  assign closed_word = s1_raw_r ^ cfg.invert_mask;

  for (genvar i = 0; i < INPUT_COUNT; i++) begin : g_cnt
    ldt_counter #(
      .COUNT_BITS (COUNT_BITS)
    ) u_counter (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .enable     (cfg.enable_mask[i]),
      .closed     (closed_word[i]),
      .elapsed_us (s1_dt_r),
      .limit_us   (cfg.limit_us),
      .level_nxt  (level_vec[i])
    );
  end

  ldt_status_map #(
    .INPUT_COUNT (INPUT_COUNT),
    .MAX_AXES    (MAX_AXES)
  ) u_status (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (advance),
    .levels          (level_vec),
    .machine_running (s1_run_r),
    .cfg             (cfg),
    .status_nxt      (status_nxt),
    .rising          (rising),
    .stop_request    (stop_request),
    .stop_cause      (stop_cause)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status_nxt;
      out_rising_r <= rising;
      out_stop_r   <= stop_request;
      out_cause_r  <= stop_cause;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status_word  = out_status_r;
  assign out_ch.rising_bits  = out_rising_r;
  assign out_ch.stop_request = out_stop_r;
  assign out_ch.stop_cause   = out_cause_r;

endmodule

// ===== rtl/ldt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ldt_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module ldt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [ldt_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ldt_pkg::CFG_DATA_W-1:0] wr_data,
  output ldt_pkg::ldt_cfg_t              cfg
);
  import ldt_pkg::*;

  ldt_cfg_t cfg_r;
  ldt_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_MIN_MAP:    cfg_nxt.min_map        = wr_data[MAP_W-1:0];
        REG_MAX_MAP:    cfg_nxt.max_map        = wr_data[MAP_W-1:0];
        REG_HOME_MAP:   cfg_nxt.home_sw_map    = wr_data[MAP_W-1:0];
        REG_STOP_PROBE: cfg_nxt.stop_probe_map = wr_data[STOP_MAP_W-1:0];
        REG_LIMIT:      cfg_nxt.limit_us       = wr_data[LIMIT_W-1:0];
        REG_AXES:       cfg_nxt.axis_count     = wr_data[AXES_W-1:0];
        REG_INVERT:     cfg_nxt.invert_mask    = wr_data[WORD_W-1:0];
        REG_ENABLE:     cfg_nxt.enable_mask    = wr_data[WORD_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r            <= '0;
      cfg_r.limit_us   <= LIMIT_RESET;
      cfg_r.axis_count <= AXES_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/ldt_counter.sv =====
// ----------------------------------------------------------------------------
// ldt_counter
// Integrating debounce counter and debounced level of one input.
// ----------------------------------------------------------------------------
module ldt_counter #(
  parameter int COUNT_BITS = ldt_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        enable,
  input  logic                        closed,
  input  logic [ldt_pkg::DT_W-1:0]    elapsed_us,
  input  logic [ldt_pkg::LIMIT_W-1:0] limit_us,
  output logic                        level_nxt
);
  import ldt_pkg::*;

  localparam int SW = ((COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W) + 2;
  localparam logic signed [SW-1:0] HI_W = SW'((64'sd1 <<< (COUNT_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] LO_W = -HI_W - SW'(1);
  localparam logic signed [SW-1:0] ZERO_W = '0;

  logic signed [COUNT_BITS-1:0] count_r;
  logic signed [COUNT_BITS-1:0] count_nxt;
  logic                         level_r;
  logic signed [SW-1:0]         cnt_w;
  logic signed [SW-1:0]         dt_w;
  logic signed [SW-1:0]         lim_w;
  logic signed [SW-1:0]         sum_w;

  function automatic logic signed [COUNT_BITS-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [COUNT_BITS-1:0] r;
    if (v > HI_W) begin
      r = HI_W[COUNT_BITS-1:0];
    end else if (v < LO_W) begin
      r = LO_W[COUNT_BITS-1:0];
    end else begin
      r = v[COUNT_BITS-1:0];
    end
    return r;
  endfunction

  assign cnt_w = SW'(count_r);
  assign dt_w  = $signed({{(SW-DT_W){1'b0}}, elapsed_us});
  assign lim_w = $signed({{(SW-LIMIT_W){1'b0}}, limit_us});
  assign sum_w = closed ? (cnt_w + dt_w) : (cnt_w - dt_w);

  always_comb begin
    count_nxt = count_r;
    level_nxt = level_r;
    if (enable) begin
      if (!closed) begin
        if (cnt_w > ZERO_W) begin
          count_nxt = sat(sum_w);
        end else begin
          count_nxt = '0;
          level_nxt = 1'b0;
        end
      end else begin
        if (cnt_w < lim_w) begin
          count_nxt = sat(sum_w);
        end else begin
          count_nxt = sat(lim_w);
          level_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      level_r <= 1'b0;
    end else if (advance) begin
      count_r <= count_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

// ===== rtl/ldt_status_map.sv =====
// ----------------------------------------------------------------------------
// ldt_status_map
// Map debounced levels to the status word, detect edges, decide stop.
// ----------------------------------------------------------------------------
module ldt_status_map #(
  parameter int INPUT_COUNT = ldt_pkg::INPUT_COUNT_DEF,
  parameter int MAX_AXES    = ldt_pkg::MAX_AXES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [INPUT_COUNT-1:0]      levels,
  input  logic                        machine_running,
  input  ldt_pkg::ldt_cfg_t           cfg,
  output logic [ldt_pkg::WORD_W-1:0]  status_nxt,
  output logic [ldt_pkg::WORD_W-1:0]  rising,
  output logic                        stop_request,
  output logic [ldt_pkg::CAUSE_W-1:0] stop_cause
);
  import ldt_pkg::*;

  localparam int LW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

  logic [WORD_W-1:0] status_r;
  logic [AXES_W-1:0] axes;
  logic              limit_edge;

  function automatic logic level_of(input logic [INPUT_COUNT-1:0] lv,
                                    input logic [IDX_W-1:0] idx);
    logic r;
    if (32'(idx) >= INPUT_COUNT) begin
      r = 1'b0;
    end else begin
      r = lv[idx[LW-1:0]];
    end
    return r;
  endfunction

  assign axes = (cfg.axis_count > AXES_W'(MAX_AXES)) ? AXES_W'(MAX_AXES) : cfg.axis_count;

  always_comb begin
    status_nxt = status_r;
    for (int a = 0; a < MAX_AXES; a++) begin
      if (AXES_W'(a) < axes) begin
        status_nxt[a*BITS_PER_AXIS]     = level_of(levels, cfg.min_map[a*IDX_W +: IDX_W]);
        status_nxt[a*BITS_PER_AXIS + 1] = level_of(levels, cfg.max_map[a*IDX_W +: IDX_W]);
        status_nxt[a*BITS_PER_AXIS + 2] = level_of(levels, cfg.home_sw_map[a*IDX_W +: IDX_W]);
      end
    end
    status_nxt[ESTOP_POS] = level_of(levels, cfg.stop_probe_map[IDX_W-1:0]);
    status_nxt[PROBE_POS] = level_of(levels, cfg.stop_probe_map[2*IDX_W-1:IDX_W]);
  end

  assign rising = status_nxt & ~status_r;

  always_comb begin
    limit_edge = 1'b0;
    for (int a = 0; a < MAX_AXES; a++) begin
      if (AXES_W'(a) < axes) begin
        if (rising[a*BITS_PER_AXIS] || rising[a*BITS_PER_AXIS + 1]) begin
          limit_edge = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (status_nxt[ESTOP_POS]) begin
      stop_cause = CAUSE_ESTOP;
    end else if (machine_running && limit_edge) begin
      stop_cause = CAUSE_LIMIT;
    end else begin
      stop_cause = CAUSE_NONE;
    end
  end

  assign stop_request = (stop_cause != CAUSE_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
    end else if (advance) begin
      status_r <= status_nxt;
    end
  end

endmodule

// ===== test/ldt_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// ldt_tb_pkg
// Trip scoreboard for the limit input debounce and trip unit. It keeps its
// own integrators, debounced levels, status word and register copy, predicts
// the result of every accepted tick and checks results in arrival order.
// ----------------------------------------------------------------------------
package ldt_tb_pkg;
  import ldt_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]  status_word;
    logic [WORD_W-1:0]  rising_bits;
    logic               stop_request;
    logic [CAUSE_W-1:0] stop_cause;
  } trip_result_t;

  localparam int REPORT_LIMIT = 10;

  class trip_scoreboard;
    ldt_cfg_t                   regs;
    longint                     integ_us [INPUT_COUNT_DEF];
    logic [INPUT_COUNT_DEF-1:0] settled;
    logic [WORD_W-1:0]          status_now;
    trip_result_t               expected_trips [$];
    int unsigned                bad_count;

    function new();
      regs            = '0;
      regs.limit_us   = LIMIT_RESET;
      regs.axis_count = AXES_RESET;
      foreach (integ_us[i]) integ_us[i] = 0;
      settled    = '0;
      status_now = '0;
      bad_count  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_MAP:    regs.min_map        = data[MAP_W-1:0];
        REG_MAX_MAP:    regs.max_map        = data[MAP_W-1:0];
        REG_HOME_MAP:   regs.home_sw_map    = data[MAP_W-1:0];
        REG_STOP_PROBE: regs.stop_probe_map = data[STOP_MAP_W-1:0];
        REG_LIMIT:      regs.limit_us       = data[LIMIT_W-1:0];
        REG_AXES:       regs.axis_count     = data[AXES_W-1:0];
        REG_INVERT:     regs.invert_mask    = data[WORD_W-1:0];
        REG_ENABLE:     regs.enable_mask    = data[WORD_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_count(longint v);
      longint top;
      top = (longint'(1) << (COUNT_BITS_DEF - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
    endfunction

    function logic level_at(logic [IDX_W-1:0] idx);
      if (int'(idx) >= INPUT_COUNT_DEF) return 1'b0;
      return settled[idx];
    endfunction

    function trip_result_t predict_trip(logic [WORD_W-1:0] raw, logic [DT_W-1:0] dt,
                                        logic run);
      trip_result_t      r;
      logic [WORD_W-1:0] closed;
      logic [WORD_W-1:0] prev;
      longint            lim;
      longint            step;
      int                axes;
      logic              limit_rise;
      lim    = longint'(regs.limit_us);
      step   = longint'(dt);
      axes   = (regs.axis_count > MAX_AXES_DEF) ? MAX_AXES_DEF : int'(regs.axis_count);
      closed = raw ^ regs.invert_mask;
      for (int i = 0; i < INPUT_COUNT_DEF; i++) begin
        if (regs.enable_mask[i]) begin
          if (!closed[i]) begin
            if (integ_us[i] > 0) begin
              integ_us[i] = clamp_count(integ_us[i] - step);
            end else begin
              integ_us[i] = 0;
              settled[i]  = 1'b0;
            end
          end else if (integ_us[i] < lim) begin
            integ_us[i] = clamp_count(integ_us[i] + step);
          end else begin
            integ_us[i] = clamp_count(lim);
            settled[i]  = 1'b1;
          end
        end
      end
      prev = status_now;
      for (int a = 0; a < axes; a++) begin
        status_now[a*BITS_PER_AXIS +: BITS_PER_AXIS] = {
          level_at(regs.home_sw_map[a*IDX_W +: IDX_W]),
          level_at(regs.max_map[a*IDX_W +: IDX_W]),
          level_at(regs.min_map[a*IDX_W +: IDX_W])};
      end
      status_now[ESTOP_POS] = level_at(regs.stop_probe_map[IDX_W-1:0]);
      status_now[PROBE_POS] = level_at(regs.stop_probe_map[2*IDX_W-1:IDX_W]);
      r.status_word = status_now;
      r.rising_bits = status_now & ~prev;
      limit_rise = 1'b0;
      for (int a = 0; a < axes; a++) begin
        if (r.rising_bits[a*BITS_PER_AXIS +: 2] != 2'b00) limit_rise = 1'b1;
      end
      if (status_now[ESTOP_POS]) r.stop_cause = CAUSE_ESTOP;
      else if (run && limit_rise) r.stop_cause = CAUSE_LIMIT;
      else r.stop_cause = CAUSE_NONE;
      r.stop_request = (r.stop_cause != CAUSE_NONE);
      return r;
    endfunction

    function void note_tick(logic [WORD_W-1:0] raw, logic [DT_W-1:0] dt, logic run);
      expected_trips.push_back(predict_trip(raw, dt, run));
    endfunction

    function void check_result(trip_result_t got);
      trip_result_t want;
      if (expected_trips.size() == 0) begin
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
          $display("unexpected result: status %h rising %h stop %b cause %0d",
                   got.status_word, got.rising_bits, got.stop_request, got.stop_cause);
        return;
      end
      want = expected_trips.pop_front();
      if (got.status_word !== want.status_word || got.rising_bits !== want.rising_bits ||
          got.stop_request !== want.stop_request || got.stop_cause !== want.stop_cause) begin
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
          $display({"result mismatch: status exp %h act %h, rising exp %h act %h, ",
                    "stop exp %b act %b, cause exp %0d act %0d"},
                   want.status_word, got.status_word, want.rising_bits, got.rising_bits,
                   want.stop_request, got.stop_request, want.stop_cause, got.stop_cause);
      end
    endfunction
  endclass

endpackage

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of the limit input debounce and trip unit. Directed ticks walk
// the integrators through setting, clamping, negative counts and stop
// priority, then register settings from the extremes upward drive long runs
// of bouncing random pin levels under random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ldt_pkg::*;
  import ldt_tb_pkg::*;

  localparam int IDLE_PCT        = 9;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASES          = 8;
  localparam int PHASE_TICKS     = 154;
  localparam int REG_COUNT       = 1 << CFG_IDX_W;

  logic clk = 1'b0;
  logic rst_n;

  ldt_in_if  in_ch ();
  ldt_out_if out_ch ();
  ldt_cfg_if cfg_ch ();

  limit_input_debounce_and_trip_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  trip_scoreboard board;
  bit             calm          = 1'b0;
  bit             hold_off_req  = 1'b0;
  int unsigned    hold_left     = 0;
  int unsigned    quiet_cycles  = 0;
  int unsigned    limit_plan [PHASES] = '{0, 1, 1000000, 250, 3000, 65535, 7000, 10000};
  int unsigned    axes_plan  [PHASES] = '{9, 0, 15, 1, 9, 12, 6, 3};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) board.write_reg(cfg_ch.index, cfg_ch.data);
      if (out_ch.valid && out_ch.ready)
        board.check_result({out_ch.status_word, out_ch.rising_bits,
                            out_ch.stop_request, out_ch.stop_cause});
      if (in_ch.valid && in_ch.ready)
        board.note_tick(in_ch.raw_levels, in_ch.elapsed_us, in_ch.machine_running);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_tick(input logic [WORD_W-1:0] raw, input logic [DT_W-1:0] dt,
                           input logic run);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_ch.valid      <= 1'b0;
      in_ch.raw_levels <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.raw_levels      <= raw;
    in_ch.elapsed_us      <= dt;
    in_ch.machine_running <= run;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.expected_trips.size() != 0);
  endtask

  task automatic load_regs(input ldt_cfg_t c, input logic [REG_COUNT-1:0] which);
    logic [CFG_DATA_W-1:0] word [REG_COUNT];
    word[REG_MIN_MAP]    = c.min_map;
    word[REG_MAX_MAP]    = c.max_map;
    word[REG_HOME_MAP]   = c.home_sw_map;
    word[REG_STOP_PROBE] = CFG_DATA_W'(c.stop_probe_map);
    word[REG_LIMIT]      = CFG_DATA_W'(c.limit_us);
    word[REG_AXES]       = CFG_DATA_W'(c.axis_count);
    word[REG_INVERT]     = CFG_DATA_W'(c.invert_mask);
    word[REG_ENABLE]     = CFG_DATA_W'(c.enable_mask);
    for (int r = 0; r < REG_COUNT; r++) begin
      if (which[r]) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_IDX_W'(r);
        cfg_ch.data  <= word[r];
        do @(posedge clk); while (!cfg_ch.ready);
      end
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic ldt_cfg_t random_regs(int p);
    ldt_cfg_t c;
    c.min_map        = MAP_W'({$urandom, $urandom});
    c.max_map        = MAP_W'({$urandom, $urandom});
    c.home_sw_map    = MAP_W'({$urandom, $urandom});
    c.stop_probe_map = STOP_MAP_W'($urandom);
    c.limit_us       = LIMIT_W'(limit_plan[p]);
    c.axis_count     = AXES_W'(axes_plan[p]);
    c.invert_mask    = $urandom;
    c.enable_mask    = $urandom | $urandom;
    case (p)
      0: begin
        c.invert_mask = '0;
        c.enable_mask = '1;
      end
      2: c.invert_mask = '1;
      3: begin
        c.min_map        = '1;
        c.max_map        = '1;
        c.home_sw_map    = '1;
        c.stop_probe_map = '1;
      end
      4: begin
        c.min_map        = '0;
        c.max_map        = '0;
        c.home_sw_map    = '0;
        c.stop_probe_map = '0;
      end
      6: begin
        c.limit_us    = LIMIT_W'($urandom_range(1, 20000));
        c.enable_mask = $urandom & $urandom;
      end
      default: ;
    endcase
    return c;
  endfunction

  // hold pins mostly steady with sparse bounces, now and then scramble them
  task automatic run_random(input int unsigned count, input int unsigned dt_cap);
    logic [WORD_W-1:0] raw;
    logic [WORD_W-1:0] flips;
    logic [DT_W-1:0]   dt;
    int unsigned       pick;
    raw = $urandom;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 80) flips = $urandom & $urandom & $urandom & $urandom & $urandom & $urandom;
      else if (pick < 95) flips = $urandom & $urandom & $urandom;
      else flips = $urandom;
      raw ^= flips;
      pick = $urandom_range(99);
      if (pick < 5) dt = '0;
      else if (pick < 10) dt = '1;
      else dt = DT_W'($urandom_range(dt_cap));
      send_tick(raw, dt, $urandom_range(99) < 70);
    end
  endtask

  initial begin
    ldt_cfg_t    plan;
    int unsigned cap;
    board = new();
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.raw_levels      <= '0;
    in_ch.elapsed_us      <= '0;
    in_ch.machine_running <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= '0;
    cfg_ch.data           <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // min on inputs 0.., max on 9.., home on 18..; e-stop 31, probe 30
    plan = '0;
    for (int a = 0; a < MAX_AXES_DEF; a++) begin
      plan.min_map[a*IDX_W +: IDX_W]     = IDX_W'(a);
      plan.max_map[a*IDX_W +: IDX_W]     = IDX_W'(a + 9);
      plan.home_sw_map[a*IDX_W +: IDX_W] = IDX_W'(a + 18);
    end
    plan.stop_probe_map = {IDX_W'(PROBE_POS), IDX_W'(ESTOP_POS)};
    plan.invert_mask    = 32'h0000_FFFF;
    plan.enable_mask    = '1;
    load_regs(plan, ~((REG_COUNT'(1) << REG_LIMIT) | (REG_COUNT'(1) << REG_AXES)));

    send_tick(32'h0000_0000, 16'd0, 1'b1);
    send_tick(32'h0000_0000, 16'hFFFF, 1'b1);
    send_tick(32'h0000_0000, 16'd1, 1'b1);
    send_tick(32'hFFFF_FFFF, 16'd100, 1'b0);
    send_tick(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_tick(32'hFFFF_FFFF, 16'd1, 1'b1);
    send_tick(32'hFFFF_0000, 16'hFFFF, 1'b1);
    send_tick(32'hFFFF_0000, 16'd1, 1'b1);
    send_tick(32'hFFFF_0000, 16'd0, 1'b0);

    // zero limit with counters above it, axis count past the top
    wait_drained();
    plan.limit_us   = '0;
    plan.axis_count = '1;
    load_regs(plan, (REG_COUNT'(1) << REG_LIMIT) | (REG_COUNT'(1) << REG_AXES));
    send_tick(32'h5555_AAAA, 16'd0, 1'b1);
    send_tick(32'h5555_AAAA, 16'd0, 1'b1);
    send_tick(32'hAAAA_5555, 16'd7, 1'b1);
    send_tick(32'hAAAA_5555, 16'd7, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      calm = (p == 1);
      plan = random_regs(p);
      load_regs(plan, '1);
      if (p == 2) hold_off_req = 1'b1;
      if (plan.limit_us == 0) cap = 64;
      else if (plan.limit_us / 2 + 1 > 65535) cap = 65535;
      else cap = plan.limit_us / 2 + 1;
      run_random(PHASE_TICKS, cap);
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.bad_count == 0 && board.expected_trips.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ldt_pkg.sv
rtl/ldt_if.sv
rtl/ldt_cfg_regs.sv
rtl/ldt_counter.sv
rtl/ldt_status_map.sv
rtl/limit_input_debounce_and_trip_unit.sv
test/ldt_tb_pkg.sv
test/tb.sv
